@@ src/tisd_pkg.sv @@
package tisd_pkg;

  // tag byte fields
  localparam logic [7:0] TagSignMask = 8'hF0;
  localparam int unsigned TagSz8Bit = 3;
  localparam int unsigned TagSz4Bit = 2;
  localparam int unsigned TagSz2Bit = 1;
  localparam int unsigned TagSz1Bit = 0;

  localparam logic [3:0] Size8 = 4'd8;
  localparam logic [3:0] Size4 = 4'd4;
  localparam logic [3:0] Size2 = 4'd2;
  localparam logic [3:0] Size1 = 4'd1;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNoSize   = 2'd1,
    StConflict = 2'd2,
    StTrunc    = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_marker;
  } in_t;

  typedef struct packed {
    logic signed [63:0] decoded_value;
    logic [3:0]         consumed_length;
    status_e            status;
  } out_t;

endpackage

@@ src/tagged_integer_stream_decoder.sv @@
// tagged integer stream decoder
//
// in channel (in_valid_i / in_ready_o / in_data_i): one stream byte per
// transaction, or an end marker that flushes a partial item as truncated.
// out channel (out_valid_o / out_ready_i / out_data_o): one transaction per
// decoded item, carrying value, bytes consumed (tag included) and status.
//
// an accepted byte lands in an input register; from there the decode logic
// updates the item state and, on the last byte of an item, a bad tag or a
// truncation, loads the result register, which drives out_valid_o. one byte
// per cycle is sustained while no byte waits behind a stalled result.
//
// a receiver stall holds the result register; bytes that do not finish an
// item keep flowing past it, and only a byte that would produce a new result
// waits in the input register until the pending result is taken.
//
// reset (rst_ni low) empties both registers and returns the decoder to
// awaiting a tag byte.
module tagged_integer_stream_decoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tisd_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tisd_pkg::out_t out_data_o
);
  import tisd_pkg::*;

  // input register
  logic in_valid_q;
  in_t  in_q;

  // item state
  logic [3:0]  bytes_left_q, bytes_left_d;
  logic [3:0]  byte_index_q, byte_index_d;
  logic [63:0] magnitude_q, magnitude_d;
  logic        negative_q, negative_d;
  logic        conflict_q, conflict_d;

  // result register
  logic out_valid_q;
  out_t out_q;

  logic emit;
  out_t res;
  logic advance;

  logic [2:0]  lane;
  logic [63:0] mag_next;
  logic [3:0]  left_next;
  logic [2:0]  size_bits;

  // decode of the byte in the input register against the item state
  always_comb begin
    bytes_left_d = bytes_left_q;
    byte_index_d = byte_index_q;
    magnitude_d  = magnitude_q;
    negative_d   = negative_q;
    conflict_d   = conflict_q;
    emit         = 1'b0;
    res          = '{decoded_value: '0, consumed_length: 4'd1, status: StOk};

    lane      = 3'(byte_index_q - 4'd1);
    mag_next  = magnitude_q | ({56'd0, in_q.data_byte} << {lane, 3'b000});
    left_next = bytes_left_q - 4'd1;
    size_bits = 3'(in_q.data_byte[0]) + 3'(in_q.data_byte[1])
              + 3'(in_q.data_byte[2]) + 3'(in_q.data_byte[3]);

    if (in_q.end_marker) begin
      // flush: a partial item is reported as truncated
      if (bytes_left_q != 4'd0) begin
        emit = 1'b1;
        res  = '{decoded_value: '0, consumed_length: byte_index_q, status: StTrunc};
      end
      bytes_left_d = '0;
      byte_index_d = '0;
      magnitude_d  = '0;
      negative_d   = 1'b0;
      conflict_d   = 1'b0;
    end else if (bytes_left_q == 4'd0) begin
      // tag byte, size bits in priority order
      byte_index_d = 4'd1;
      magnitude_d  = '0;
      negative_d   = (in_q.data_byte & TagSignMask) != 8'd0;
      conflict_d   = size_bits > 3'd1;
      if (in_q.data_byte[TagSz8Bit])      bytes_left_d = Size8;
      else if (in_q.data_byte[TagSz4Bit]) bytes_left_d = Size4;
      else if (in_q.data_byte[TagSz2Bit]) bytes_left_d = Size2;
      else if (in_q.data_byte[TagSz1Bit]) bytes_left_d = Size1;
      else begin
        // no size bit: report at once and wait for the next tag
        emit         = 1'b1;
        res          = '{decoded_value: '0, consumed_length: 4'd1, status: StNoSize};
        bytes_left_d = '0;
        byte_index_d = '0;
        negative_d   = 1'b0;
        conflict_d   = 1'b0;
      end
    end else begin
      // payload byte, little endian
      magnitude_d  = mag_next;
      byte_index_d = byte_index_q + 4'd1;
      bytes_left_d = left_next;
      if (left_next == 4'd0) begin
        emit              = 1'b1;
        res.decoded_value = negative_q ? 64'(64'd0 - mag_next) : mag_next;
        res.consumed_length = byte_index_q + 4'd1;
        res.status        = conflict_q ? StConflict : StOk;
        byte_index_d      = '0;
        magnitude_d       = '0;
        negative_d        = 1'b0;
        conflict_d        = 1'b0;
      end
    end
  end

  // the held byte moves on unless it makes a result that has no room
  assign advance    = in_valid_q && (!emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      bytes_left_q <= '0;
      byte_index_q <= '0;
      magnitude_q  <= '0;
      negative_q   <= 1'b0;
      conflict_q   <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        bytes_left_q <= bytes_left_d;
        byte_index_q <= byte_index_d;
        magnitude_q  <= magnitude_d;
        negative_q   <= negative_d;
        conflict_q   <= conflict_d;
      end
      if (advance && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ src/tisd_checker.sv @@
module tisd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input tisd_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input tisd_pkg::out_t out_data_o
);
  import tisd_pkg::*;

  // a waiting input transaction stays offered with the same payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input transaction changed while waiting");

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a bad tag consumes only itself and gives zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StNoSize |->
      out_data_o.consumed_length == 4'd1 && out_data_o.decoded_value == 64'sd0)
    else $error("bad tag result malformed");

  // a truncated item gives zero and a nonzero count short of a full 8-byte item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StTrunc |->
      out_data_o.decoded_value == 64'sd0 && out_data_o.consumed_length != 4'd0
      && out_data_o.consumed_length != 4'd9)
    else $error("truncated result malformed");

  // a completed item spans the tag plus 1, 2, 4 or 8 payload bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == StOk || out_data_o.status == StConflict) |->
      out_data_o.consumed_length == 4'd2 || out_data_o.consumed_length == 4'd3
      || out_data_o.consumed_length == 4'd5 || out_data_o.consumed_length == 4'd9)
    else $error("completed item has impossible length");

endmodule

bind tagged_integer_stream_decoder tisd_checker u_tisd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
